>>> src/cde_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date engine package
// Shared constants, operation codes, command and status types, month table.
// ----------------------------------------------------------------------------
package cde_pkg;

  localparam int OP_W       = 2;
  localparam int DAY_W      = 5;
  localparam int MON_W      = 4;
  localparam int YEAR_W     = 12;
  localparam int AMT_W      = 16;
  localparam int DCOUNT_W   = 16;
  localparam int WDAY_W     = 3;
  localparam int MOD100_W   = 7;
  localparam int MOD400_W   = 9;
  localparam int YLEN_W     = 9;

  localparam int DEF_YEAR_SPAN = 128;
  localparam int EPOCH_YEAR    = 1970;
  localparam int EPOCH_MOD100  = EPOCH_YEAR % 100;
  localparam int EPOCH_MOD400  = EPOCH_YEAR % 400;
  localparam int DAYS_YEAR     = 365;
  localparam int DAYS_LEAP     = 366;
  localparam int MONTHS        = 12;

  typedef enum logic [OP_W-1:0] {
    OP_SET        = 2'd0,
    OP_ADD_DAYS   = 2'd1,
    OP_ADD_MONTHS = 2'd2,
    OP_ADD_YEARS  = 2'd3
  } cde_op_t;

  typedef struct packed {
    logic accept;
    logic init_epoch;
    logic init_cur;
    logic init_days;
    logic step_year_acc;
    logic step_mon_acc;
    logic mark_year;
    logic start_month;
    logic commit_set;
    logic check_load;
    logic step_year_sub;
    logic step_mon_sub;
    logic commit_load;
    logic step_wd;
    logic set_err;
    logic out_load;
  } cde_cmd_t;

  typedef struct packed {
    cde_op_t op;
    logic    range_ok;
    logic    year_hit;
    logic    mon_hit;
    logic    day_ok;
    logic    walk_done;
    logic    over;
    logic    year_fits;
    logic    mon_fits;
    logic    wd_done;
    logic    out_free;
  } cde_sts_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                        d = leap ? 5'd29 : 5'd28;
      default:                                     d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

>>> src/cde_ifs.sv
// ----------------------------------------------------------------------------
// Calendar date engine channels
// Valid/ready channels for operation requests and date results.
// ----------------------------------------------------------------------------
interface cde_in_if;
  import cde_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [DAY_W-1:0]    day_in;
  logic [MON_W-1:0]    month_in;
  logic [YEAR_W-1:0]   year_in;
  logic [AMT_W-1:0]    amount;

  modport src (output valid, operation, day_in, month_in, year_in, amount,
               input ready);
  modport snk (input valid, operation, day_in, month_in, year_in, amount,
               output ready);
endinterface

interface cde_out_if;
  import cde_pkg::*;

  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    day_out;
  logic [MON_W-1:0]    month_out;
  logic [YEAR_W-1:0]   year_out;
  logic [DCOUNT_W-1:0] day_count;
  logic [WDAY_W-1:0]   weekday;
  logic                error;

  modport src (output valid, day_out, month_out, year_out, day_count, weekday,
               error, input ready);
  modport snk (input valid, day_out, month_out, year_out, day_count, weekday,
               error, output ready);
endinterface

>>> src/cde_ctrl.sv
// ----------------------------------------------------------------------------
// Calendar date engine controller
// Sequences validation, month and year walks, reload and weekday reduction.
// ----------------------------------------------------------------------------
module cde_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cde_pkg::cde_sts_t sts,
  output cde_pkg::cde_cmd_t cmd
);
  import cde_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_START = 11'b000_0000_0010,
    S_SET_Y = 11'b000_0000_0100,
    S_SET_M = 11'b000_0000_1000,
    S_SUM_M = 11'b000_0001_0000,
    S_SUM_Y = 11'b000_0010_0000,
    S_CHECK = 11'b000_0100_0000,
    S_LOAD_Y = 11'b000_1000_0000,
    S_LOAD_M = 11'b001_0000_0000,
    S_WDAY  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } cde_state_t;

  cde_state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        case (sts.op)
          OP_SET: begin
            if (sts.range_ok) begin
              cmd.init_epoch = 1'b1;
              state_nxt      = S_SET_Y;
            end else begin
              cmd.set_err = 1'b1;
              state_nxt   = S_FIN;
            end
          end
          OP_ADD_DAYS: begin
            cmd.init_days = 1'b1;
            state_nxt     = S_CHECK;
          end
          OP_ADD_MONTHS: begin
            cmd.init_cur = 1'b1;
            state_nxt    = S_SUM_M;
          end
          OP_ADD_YEARS: begin
            cmd.init_cur = 1'b1;
            state_nxt    = S_SUM_Y;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_SET_Y: begin
        if (sts.year_hit) begin
          cmd.mark_year   = 1'b1;
          cmd.start_month = 1'b1;
          state_nxt       = S_SET_M;
        end else begin
          cmd.step_year_acc = 1'b1;
        end
      end
      S_SET_M: begin
        if (sts.mon_hit) begin
          if (sts.day_ok) begin
            cmd.commit_set = 1'b1;
            state_nxt      = S_WDAY;
          end else begin
            cmd.set_err = 1'b1;
            state_nxt   = S_FIN;
          end
        end else begin
          cmd.step_mon_acc = 1'b1;
        end
      end
      S_SUM_M: begin
        if (sts.walk_done) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.step_mon_acc = 1'b1;
        end
      end
      S_SUM_Y: begin
        if (sts.walk_done) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.step_year_acc = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts.over) begin
          cmd.set_err = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.check_load = 1'b1;
          state_nxt      = S_LOAD_Y;
        end
      end
      S_LOAD_Y: begin
        if (sts.year_fits) begin
          cmd.start_month = 1'b1;
          state_nxt       = S_LOAD_M;
        end else begin
          cmd.step_year_sub = 1'b1;
        end
      end
      S_LOAD_M: begin
        if (sts.mon_fits) begin
          cmd.commit_load = 1'b1;
          state_nxt       = S_WDAY;
        end else begin
          cmd.step_mon_sub = 1'b1;
        end
      end
      S_WDAY: begin
        if (sts.wd_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.step_wd = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/cde_dp.sv
// ----------------------------------------------------------------------------
// Calendar date engine datapath
// Current date state, year and month walker, day accumulator, weekday
// reduction and the result register.
// ----------------------------------------------------------------------------
module cde_dp #(
  parameter int YEAR_SPAN = cde_pkg::DEF_YEAR_SPAN
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cde_pkg::cde_cmd_t              cmd,
  output cde_pkg::cde_sts_t              sts,
  input  logic [cde_pkg::OP_W-1:0]       operation,
  input  logic [cde_pkg::DAY_W-1:0]      day_in,
  input  logic [cde_pkg::MON_W-1:0]      month_in,
  input  logic [cde_pkg::YEAR_W-1:0]     year_in,
  input  logic [cde_pkg::AMT_W-1:0]      amount,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [cde_pkg::DAY_W-1:0]      day_out,
  output logic [cde_pkg::MON_W-1:0]      month_out,
  output logic [cde_pkg::YEAR_W-1:0]     year_out,
  output logic [cde_pkg::DCOUNT_W-1:0]   day_count,
  output logic [cde_pkg::WDAY_W-1:0]     weekday,
  output logic                           error
);
  import cde_pkg::*;

  localparam int LAST_YEAR = EPOCH_YEAR + YEAR_SPAN - 1;
  localparam int LEAPS_LAST = LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400;
  localparam int LEAPS_PRE = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                             + (EPOCH_YEAR - 1) / 400;
  localparam int LIM   = DAYS_YEAR * YEAR_SPAN + LEAPS_LAST - LEAPS_PRE - 1;
  localparam int CNT_W = $clog2(DAYS_LEAP * YEAR_SPAN);
  localparam int SUM_W = ((CNT_W > AMT_W) ? CNT_W : AMT_W) + 2;

  // Current date.
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [MON_W-1:0]    mon_r, mon_nxt;
  logic [YEAR_W-1:0]   yr_r, yr_nxt;
  logic [MOD100_W-1:0] cy100_r, cy100_nxt;
  logic [MOD400_W-1:0] cy400_r, cy400_nxt;
  logic [CNT_W-1:0]    ela_r, ela_nxt;
  logic [CNT_W-1:0]    ys_r, ys_nxt;
  logic [2:0]          r7_r, r7_nxt;

  // Latched request.
  cde_op_t             op_r, op_nxt;
  logic [DAY_W-1:0]    d_r, d_nxt;
  logic [MON_W-1:0]    m_r, m_nxt;
  logic [YEAR_W-1:0]   y_r, y_nxt;
  logic [AMT_W-1:0]    cnt_r, cnt_nxt;
  logic                err_r, err_nxt;

  // Walker.
  logic [YEAR_W-1:0]   wy_r, wy_nxt;
  logic [MOD100_W-1:0] w100_r, w100_nxt;
  logic [MOD400_W-1:0] w400_r, w400_nxt;
  logic [MON_W-1:0]    wm_r, wm_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    ws_r, ws_nxt;
  logic [CNT_W-1:0]    sh_r, sh_nxt;

  // Result register.
  logic                ov_r, ov_nxt;
  logic [DAY_W-1:0]    o_day_r, o_day_nxt;
  logic [MON_W-1:0]    o_mon_r, o_mon_nxt;
  logic [YEAR_W-1:0]   o_yr_r, o_yr_nxt;
  logic [DCOUNT_W-1:0] o_cnt_r, o_cnt_nxt;
  logic [WDAY_W-1:0]   o_wd_r, o_wd_nxt;
  logic                o_err_r, o_err_nxt;

  logic                leap;
  logic [YLEN_W-1:0]   ylen;
  logic [DAY_W-1:0]    dim;
  logic [YEAR_W-1:0]   wy_inc;
  logic [MOD100_W-1:0] w100_inc;
  logic [MOD400_W-1:0] w400_inc;
  logic [SUM_W-1:0]    tot;
  logic [3:0]          r7_sum;
  logic [WDAY_W-1:0]   wd_cur;
  logic [CNT_W+DCOUNT_W-1:0] ela_ext;

  assign leap     = ((wy_r[1:0] == 2'd0) && (w100_r != '0)) || (w400_r == '0);
  assign ylen     = leap ? YLEN_W'(DAYS_LEAP) : YLEN_W'(DAYS_YEAR);
  assign dim      = month_days(wm_r, leap);
  assign wy_inc   = wy_r + 1'b1;
  assign w100_inc = (w100_r == MOD100_W'(99))  ? '0 : w100_r + 1'b1;
  assign w400_inc = (w400_r == MOD400_W'(399)) ? '0 : w400_r + 1'b1;
  assign tot      = SUM_W'(ela_r) + acc_r;
  assign r7_sum   = {1'b0, r7_r} + {1'b0, sh_r[2:0]};
  assign wd_cur   = (r7_r >= 3'd4) ? r7_r - 3'd3 : r7_r + 3'd4;
  assign ela_ext  = {{DCOUNT_W{1'b0}}, ela_r};

  always_comb begin
    sts.op        = op_r;
    sts.range_ok  = (d_r != '0) && (m_r >= 4'd1) && (m_r <= MON_W'(MONTHS)) &&
                    (y_r >= YEAR_W'(EPOCH_YEAR)) && (y_r <= YEAR_W'(LAST_YEAR));
    sts.year_hit  = (wy_r == y_r);
    sts.mon_hit   = (wm_r == m_r);
    sts.day_ok    = (d_r <= dim);
    sts.walk_done = (cnt_r == '0) || (acc_r > SUM_W'(LIM));
    sts.over      = (tot > SUM_W'(LIM));
    sts.year_fits = (acc_r < SUM_W'(ylen));
    sts.mon_fits  = (acc_r < SUM_W'(dim));
    sts.wd_done   = (sh_r == '0);
    sts.out_free  = !ov_r || out_ready;
  end

  always_comb begin
    day_nxt   = day_r;
    mon_nxt   = mon_r;
    yr_nxt    = yr_r;
    cy100_nxt = cy100_r;
    cy400_nxt = cy400_r;
    ela_nxt   = ela_r;
    ys_nxt    = ys_r;
    r7_nxt    = r7_r;
    op_nxt    = op_r;
    d_nxt     = d_r;
    m_nxt     = m_r;
    y_nxt     = y_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    wy_nxt    = wy_r;
    w100_nxt  = w100_r;
    w400_nxt  = w400_r;
    wm_nxt    = wm_r;
    acc_nxt   = acc_r;
    ws_nxt    = ws_r;
    sh_nxt    = sh_r;

    if (cmd.accept) begin
      op_nxt  = cde_op_t'(operation);
      d_nxt   = day_in;
      m_nxt   = month_in;
      y_nxt   = year_in;
      cnt_nxt = amount;
      err_nxt = 1'b0;
    end
    if (cmd.set_err) begin
      err_nxt = 1'b1;
    end
    if (cmd.init_epoch) begin
      wy_nxt   = YEAR_W'(EPOCH_YEAR);
      w100_nxt = MOD100_W'(EPOCH_MOD100);
      w400_nxt = MOD400_W'(EPOCH_MOD400);
      acc_nxt  = '0;
    end
    if (cmd.init_cur) begin
      wy_nxt   = yr_r;
      w100_nxt = cy100_r;
      w400_nxt = cy400_r;
      wm_nxt   = mon_r;
      acc_nxt  = '0;
    end
    if (cmd.init_days) begin
      acc_nxt = SUM_W'(cnt_r);
    end
    if (cmd.step_year_acc || cmd.step_year_sub) begin
      wy_nxt   = wy_inc;
      w100_nxt = w100_inc;
      w400_nxt = w400_inc;
    end
    if (cmd.step_year_acc) begin
      acc_nxt = acc_r + SUM_W'(ylen);
      cnt_nxt = cnt_r - 1'b1;
    end
    if (cmd.step_year_sub) begin
      acc_nxt = acc_r - SUM_W'(ylen);
      ws_nxt  = ws_r + CNT_W'(ylen);
    end
    if (cmd.step_mon_acc) begin
      acc_nxt = acc_r + SUM_W'(dim);
      cnt_nxt = cnt_r - 1'b1;
      if (wm_r == MON_W'(MONTHS)) begin
        wm_nxt   = 4'd1;
        wy_nxt   = wy_inc;
        w100_nxt = w100_inc;
        w400_nxt = w400_inc;
      end else begin
        wm_nxt = wm_r + 1'b1;
      end
    end
    if (cmd.step_mon_sub) begin
      acc_nxt = acc_r - SUM_W'(dim);
      wm_nxt  = wm_r + 1'b1;
    end
    if (cmd.mark_year) begin
      ws_nxt = acc_r[CNT_W-1:0];
    end
    if (cmd.start_month) begin
      wm_nxt = 4'd1;
    end
    if (cmd.check_load) begin
      ela_nxt  = tot[CNT_W-1:0];
      acc_nxt  = tot - SUM_W'(ys_r);
      wy_nxt   = yr_r;
      w100_nxt = cy100_r;
      w400_nxt = cy400_r;
      ws_nxt   = ys_r;
    end
    if (cmd.commit_set) begin
      day_nxt   = d_r;
      mon_nxt   = m_r;
      yr_nxt    = wy_r;
      cy100_nxt = w100_r;
      cy400_nxt = w400_r;
      ys_nxt    = ws_r;
      ela_nxt   = acc_r[CNT_W-1:0] + CNT_W'(d_r) - 1'b1;
    end
    if (cmd.commit_load) begin
      day_nxt   = acc_r[DAY_W-1:0] + 1'b1;
      mon_nxt   = wm_r;
      yr_nxt    = wy_r;
      cy100_nxt = w100_r;
      cy400_nxt = w400_r;
      ys_nxt    = ws_r;
    end
    if (cmd.commit_set || cmd.commit_load) begin
      sh_nxt = ela_nxt;
      r7_nxt = '0;
    end
    if (cmd.step_wd) begin
      r7_nxt = (r7_sum >= 4'd7) ? 3'(r7_sum - 4'd7) : r7_sum[2:0];
      sh_nxt = sh_r >> 3;
    end
  end

  always_comb begin
    ov_nxt    = ov_r;
    o_day_nxt = o_day_r;
    o_mon_nxt = o_mon_r;
    o_yr_nxt  = o_yr_r;
    o_cnt_nxt = o_cnt_r;
    o_wd_nxt  = o_wd_r;
    o_err_nxt = o_err_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      ov_nxt    = 1'b1;
      o_day_nxt = day_r;
      o_mon_nxt = mon_r;
      o_yr_nxt  = yr_r;
      o_cnt_nxt = ela_ext[DCOUNT_W-1:0];
      o_wd_nxt  = wd_cur;
      o_err_nxt = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= DAY_W'(1);
      mon_r   <= MON_W'(1);
      yr_r    <= YEAR_W'(EPOCH_YEAR);
      cy100_r <= MOD100_W'(EPOCH_MOD100);
      cy400_r <= MOD400_W'(EPOCH_MOD400);
      ela_r   <= '0;
      ys_r    <= '0;
      r7_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      day_r   <= day_nxt;
      mon_r   <= mon_nxt;
      yr_r    <= yr_nxt;
      cy100_r <= cy100_nxt;
      cy400_r <= cy400_nxt;
      ela_r   <= ela_nxt;
      ys_r    <= ys_nxt;
      r7_r    <= r7_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    d_r     <= d_nxt;
    m_r     <= m_nxt;
    y_r     <= y_nxt;
    cnt_r   <= cnt_nxt;
    err_r   <= err_nxt;
    wy_r    <= wy_nxt;
    w100_r  <= w100_nxt;
    w400_r  <= w400_nxt;
    wm_r    <= wm_nxt;
    acc_r   <= acc_nxt;
    ws_r    <= ws_nxt;
    sh_r    <= sh_nxt;
    o_day_r <= o_day_nxt;
    o_mon_r <= o_mon_nxt;
    o_yr_r  <= o_yr_nxt;
    o_cnt_r <= o_cnt_nxt;
    o_wd_r  <= o_wd_nxt;
    o_err_r <= o_err_nxt;
  end

  assign out_valid = ov_r;
  assign day_out   = o_day_r;
  assign month_out = o_mon_r;
  assign year_out  = o_yr_r;
  assign day_count = o_cnt_r;
  assign weekday   = o_wd_r;
  assign error     = o_err_r;

endmodule

>>> src/calendar_date_engine_unit.sv
// ----------------------------------------------------------------------------
// Calendar date engine
// Gregorian date keeper with set, add days, add months and add years.
// ----------------------------------------------------------------------------
// The block holds one date from 1970-01-01 through the last day of year
// 1970 + YEAR_SPAN - 1, its day count and its ISO weekday, and returns one
// result per request. Requests are handled one at a time by a walker that
// steps one year or one month per clock. Setting a date walks the years from
// 1970 to its year, then its months; adding months or years first sums one
// month or one year per cycle over the amount, stopping early once the sum
// passes the last supported day, and every add that stays in range then walks
// forward from the current year to the target year and through its months.
// Each accepted change ends with a weekday reduction of one octal digit of
// the day count per cycle. A new request is taken while the previous result
// still waits in the output register.
// ----------------------------------------------------------------------------
module calendar_date_engine_unit #(
  parameter int YEAR_SPAN = cde_pkg::DEF_YEAR_SPAN
) (
  input logic   clk,
  input logic   rst_n,
  cde_in_if.snk in_ch,
  cde_out_if.src out_ch
);
  import cde_pkg::*;

  cde_cmd_t cmd;
  cde_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  cde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cde_dp #(
    .YEAR_SPAN (YEAR_SPAN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .operation (in_ch.operation),
    .day_in    (in_ch.day_in),
    .month_in  (in_ch.month_in),
    .year_in   (in_ch.year_in),
    .amount    (in_ch.amount),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .day_out   (out_ch.day_out),
    .month_out (out_ch.month_out),
    .year_out  (out_ch.year_out),
    .day_count (out_ch.day_count),
    .weekday   (out_ch.weekday),
    .error     (out_ch.error)
  );

endmodule

>>> bench/cde_date_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date engine result checker
// Watches the request and result channels. Every accepted request is run
// through a local model of the calendar state, and each accepted result is
// compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cde_date_checker #(
  parameter int YEAR_SPAN = cde_pkg::DEF_YEAR_SPAN
) (
  input  logic clk,
  input  logic rst_n,
  cde_in_if    in_ch,
  cde_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   rejected
);
  import cde_pkg::*;

  localparam int unsigned LAST_YEAR = EPOCH_YEAR + YEAR_SPAN - 1;

  typedef struct packed {
    logic [DAY_W-1:0]    day;
    logic [MON_W-1:0]    month;
    logic [YEAR_W-1:0]   year;
    logic [DCOUNT_W-1:0] count;
    logic [WDAY_W-1:0]   wday;
    logic                err;
  } date_report_t;

  date_report_t expected_dates[$];
  int unsigned  cal_day;
  int unsigned  cal_month;
  int unsigned  cal_year;
  int unsigned  cal_count;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    rejected   = 0;
  end

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int unsigned year_length(input int unsigned y);
    return is_leap(y) ? DAYS_LEAP : DAYS_YEAR;
  endfunction

  function automatic int unsigned days_to_year(input int unsigned y);
    int unsigned total;
    total = 0;
    for (int unsigned k = EPOCH_YEAR; k < y; k++) total += year_length(k);
    return total;
  endfunction

  function automatic void move_to_count(input int unsigned c);
    int unsigned y;
    int unsigned m;
    int unsigned r;
    y = EPOCH_YEAR;
    m = 1;
    r = c;
    while (r >= year_length(y)) begin
      r -= year_length(y);
      y++;
    end
    while (r >= month_length(m, y)) begin
      r -= month_length(m, y);
      m++;
    end
    cal_year  = y;
    cal_month = m;
    cal_day   = r + 1;
    cal_count = c;
  endfunction

  function automatic date_report_t advance_calendar(input cde_op_t op,
                                                    input int unsigned d,
                                                    input int unsigned m,
                                                    input int unsigned y,
                                                    input int unsigned n);
    int unsigned     last_count;
    int unsigned     mm;
    int unsigned     yy;
    int unsigned     c;
    int unsigned     wd;
    longint unsigned span;
    logic            bad;
    date_report_t    r;
    last_count = days_to_year(LAST_YEAR + 1) - 1;
    bad  = 1'b0;
    span = 0;
    mm   = cal_month;
    yy   = cal_year;
    case (op)
      OP_SET: begin
        if (d == 0 || m < 1 || m > MONTHS || y < EPOCH_YEAR || y > LAST_YEAR ||
            d > month_length(m, y)) begin
          bad = 1'b1;
        end else begin
          c = days_to_year(y);
          for (int unsigned k = 1; k < m; k++) c += month_length(k, y);
          cal_day   = d;
          cal_month = m;
          cal_year  = y;
          cal_count = c + d - 1;
        end
      end
      OP_ADD_DAYS: span = n;
      OP_ADD_MONTHS: begin
        for (int unsigned k = 0; k < n && span <= last_count; k++) begin
          span += month_length(mm, yy);
          mm++;
          if (mm > MONTHS) begin
            mm = 1;
            yy++;
          end
        end
      end
      default: begin
        for (int unsigned k = 0; k < n && span <= last_count; k++) begin
          span += year_length(yy);
          yy++;
        end
      end
    endcase
    if (op != OP_SET) begin
      if (cal_count + span > last_count) bad = 1'b1;
      else move_to_count(32'(cal_count + span));
    end
    // Day zero of the count is a Thursday.
    wd = cal_count % 7 + 4;
    if (wd >= 8) wd -= 7;
    r.day   = DAY_W'(cal_day);
    r.month = MON_W'(cal_month);
    r.year  = YEAR_W'(cal_year);
    r.count = DCOUNT_W'(cal_count);
    r.wday  = WDAY_W'(wd);
    r.err   = bad;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    date_report_t want;
    if (!rst_n) begin
      cal_day   = 1;
      cal_month = 1;
      cal_year  = EPOCH_YEAR;
      cal_count = 0;
      expected_dates.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %0d-%0d-%0d",
                   $time, out_ch.year_out, out_ch.month_out, out_ch.day_out);
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          checked++;
          if (want.err) rejected++;
          compare_field("day_out", 16'(want.day), 16'(out_ch.day_out));
          compare_field("month_out", 16'(want.month), 16'(out_ch.month_out));
          compare_field("year_out", 16'(want.year), 16'(out_ch.year_out));
          compare_field("day_count", 16'(want.count), 16'(out_ch.day_count));
          compare_field("weekday", 16'(want.wday), 16'(out_ch.weekday));
          compare_field("error", 16'(want.err), 16'(out_ch.error));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_dates.push_back(advance_calendar(cde_op_t'(in_ch.operation),
                                                  32'(in_ch.day_in),
                                                  32'(in_ch.month_in),
                                                  32'(in_ch.year_in),
                                                  32'(in_ch.amount)));
      end
    end
    pending = expected_dates.size();
  end

endmodule

>>> bench/tb_calendar_date_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date engine testbench
// Drives directed date edges, leap days, invalid dates and range overflows,
// then weighted random set and add requests with random idling on both
// channels, one long result hold-off and one stretch without idling. The
// checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_calendar_date_engine_unit;
  import cde_pkg::*;

  localparam int     IDLE_PCT        = 18;
  localparam int     RANDOM_REQUESTS = 1700;
  localparam int     HOLD_START      = 300;
  localparam int     HOLD_CYCLES     = 2500;
  localparam int     STEADY_FIRST    = 700;
  localparam int     STEADY_LAST     = 1000;
  localparam int     DRAIN_CYCLES    = 2000;
  localparam int     LAST_YEAR       = EPOCH_YEAR + DEF_YEAR_SPAN - 1;
  localparam longint CYCLE_LIMIT     = 10_000_000;

  logic   clk;
  logic   rst_n;
  int     fail_count;
  int     pending;
  int     checked;
  int     rejected;
  int     accepted;
  longint cycle_count = 0;
  bit     steady;
  bit     hold_armed;

  cde_in_if  req_ch();
  cde_out_if rsp_ch();

  calendar_date_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  cde_date_checker date_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (req_ch),
    .out_ch     (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .rejected   (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // The long hold-off lets the engine fill up and stall its request channel.
  initial begin
    int held;
    held = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && held < HOLD_CYCLES) begin
        rsp_ch.ready <= 1'b0;
        held++;
      end else if (steady) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_request(input cde_op_t op, input int unsigned d,
                              input int unsigned m, input int unsigned y,
                              input int unsigned n);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.day_in    <= DAY_W'(d);
    req_ch.month_in  <= MON_W'(m);
    req_ch.year_in   <= YEAR_W'(y);
    req_ch.amount    <= AMT_W'(n);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    accepted++;
  endtask

  initial begin
    int                i;
    int unsigned       pick;
    int unsigned       sel;
    cde_op_t           op;
    int unsigned       amt;
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= OP_SET;
    req_ch.day_in      <= '0;
    req_ch.month_in    <= '0;
    req_ch.year_in     <= '0;
    req_ch.amount      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_request(OP_SET, 1, 1, EPOCH_YEAR, 0);
    send_request(OP_ADD_DAYS, 0, 0, 0, 0);
    send_request(OP_ADD_MONTHS, 0, 0, 0, 0);
    send_request(OP_ADD_YEARS, 0, 0, 0, 0);
    send_request(OP_SET, 31, 12, LAST_YEAR, 0);
    send_request(OP_ADD_DAYS, 0, 0, 0, 1);
    send_request(OP_ADD_MONTHS, 0, 0, 0, 1);
    send_request(OP_ADD_YEARS, 0, 0, 0, 1);
    send_request(OP_SET, 29, 2, 2000, 0);
    send_request(OP_SET, 29, 2, 2001, 0);
    send_request(OP_SET, 29, 2, 2096, 0);
    send_request(OP_SET, 0, 3, 2000, 0);
    send_request(OP_SET, 1, 0, 2000, 0);
    send_request(OP_SET, 1, 13, 2000, 0);
    send_request(OP_SET, '1, '1, '1, '1);
    send_request(OP_SET, 1, 1, EPOCH_YEAR - 1, 0);
    send_request(OP_SET, 1, 1, LAST_YEAR + 1, 0);
    send_request(OP_SET, 31, 4, 2021, 0);
    send_request(OP_SET, 31, 1, EPOCH_YEAR, 0);
    send_request(OP_ADD_MONTHS, 0, 0, 0, 1);
    send_request(OP_ADD_YEARS, 0, 0, 0, DEF_YEAR_SPAN - 1);
    send_request(OP_ADD_DAYS, 0, 0, 0, '1);
    send_request(OP_ADD_MONTHS, 0, 0, 0, '1);
    send_request(OP_ADD_YEARS, 0, 0, 0, '1);
    send_request(OP_SET, 1, 1, EPOCH_YEAR, 0);
    send_request(OP_ADD_DAYS, 0, 0, 0, 46751);

    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      steady = (i >= STEADY_FIRST && i < STEADY_LAST);
      if (i == HOLD_START) hold_armed = 1'b1;
      pick = $urandom_range(99);
      sel  = $urandom_range(19);
      if (pick < 25) begin
        if (sel < 4) begin
          send_request(OP_SET, $urandom, $urandom, $urandom, $urandom);
        end else begin
          send_request(OP_SET,
                       (sel == 4) ? $urandom_range(29, 31) : $urandom_range(1, 28),
                       $urandom_range(1, MONTHS), $urandom_range(EPOCH_YEAR, LAST_YEAR),
                       $urandom);
        end
      end else begin
        if (pick < 55) begin
          op  = OP_ADD_DAYS;
          amt = (sel == 0) ? $urandom : (sel == 1) ? $urandom_range(0, 46751) :
                $urandom_range(0, 400);
        end else if (pick < 80) begin
          op  = OP_ADD_MONTHS;
          amt = (sel == 0) ? $urandom : (sel == 1) ? $urandom_range(0, 1600) :
                $urandom_range(0, 36);
        end else begin
          op  = OP_ADD_YEARS;
          amt = (sel == 0) ? $urandom : (sel == 1) ? $urandom_range(0, 140) :
                $urandom_range(0, 10);
        end
        send_request(op, $urandom, $urandom, $urandom, amt);
      end
    end
    req_ch.valid <= 1'b0;
    steady = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests transferred: %0d, results compared: %0d, rejected by the engine: %0d",
             accepted, checked, rejected);
    $display("covered date limits, leap days, invalid dates, overflow, hold-off and random mix");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
